// ===== rtl/iodsq_pkg.sv =====
// iodsq_pkg: codes, register indexes and reset values shared by the
// i/o device service queue block and its port checker.
// no dependencies.
package iodsq_pkg;

	// operation codes of an input item
	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_COMPLETE = 2'd0;
	localparam logic [1:0] KIND_ACCEPT   = 2'd1;
	localparam logic [1:0] KIND_REJECT   = 2'd2;

	// configuration register indexes
	localparam int          CFG_IDX_W               = 3;
	localparam int          CFG_DATA_W              = 8;
	localparam logic [2:0] REG_DISK_DURATION       = 3'd0;
	localparam logic [2:0] REG_TAPE_DURATION       = 3'd1;
	localparam logic [2:0] REG_PRINTER_DURATION    = 3'd2;
	localparam logic [2:0] REG_DISK_PRIORITY       = 3'd3;
	localparam logic [2:0] REG_TAPE_PRIORITY       = 3'd4;
	localparam logic [2:0] REG_PRINTER_PRIORITY    = 3'd5;

	// one duration and one priority register per device class
	localparam int NUM_CLASSES = 3;
	localparam int MAX_DEVICES = 8;

	localparam logic [7:0] DUR_RESET  [NUM_CLASSES] = '{8'd4, 8'd7, 8'd20};
	localparam logic [1:0] PRIO_RESET [NUM_CLASSES] = '{2'd1, 2'd0, 2'd0};

	// countdown reset per device, classes repeat every three devices
	localparam logic [7:0] DEV_DUR_RESET [MAX_DEVICES] =
		'{8'd4, 8'd7, 8'd20, 8'd4, 8'd7, 8'd20, 8'd4, 8'd7};

endpackage

// ===== rtl/io_device_service_queues.sv =====
// io_device_service_queues: top level, per-device pid fifos in one shared
// memory with service countdowns, stepped by a small sequencer.
// depends on iodsq_pkg.
//
// A request item passes through the ST_REQ state and gives one registered
// result. A tick item walks the devices one at a time through a single
// countdown and fifo datapath: a check step (ST_TCHK) for every device, plus
// an output step (ST_TOUT) for each device that completes, since the fifo
// memory has a registered read port; the block then returns to idle, where
// the next item is taken. busy is high until the block is back in idle.
// Results appear on the output ports for exactly one cycle with strobe high
// and must be taken then; the last result of an item carries last. A tick
// that completes nothing gives no result. The fifo memory needs no clearing
// after reset. Configuration may be written only while busy is low.
module io_device_service_queues #(
	parameter int DEVICES     = 3,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [1:0]  device,
	input  logic [7:0]  pid,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [1:0]  unit,
	output logic [7:0]  process_id,
	output logic [1:0]  return_priority,
	output logic        last
);

	localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int SW = QW + 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int MD = DEVICES * QUEUE_DEPTH;
	localparam int AW = $clog2(MD);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REQ,
		ST_TCHK,
		ST_TOUT
	} state_t;

	state_t          state_q;
	logic [DW-1:0]   cur_q;
	logic [1:0]      ridx_q;
	logic [1:0]      dev_q;
	logic [7:0]      pid_q;
	logic            bad_q;

	logic [QW-1:0]   head_q [DEVICES];
	logic [FW-1:0]   fill_q [DEVICES];
	logic [7:0]      cd_q   [DEVICES];
	logic [7:0]      dur_q  [iodsq_pkg::NUM_CLASSES];
	logic [1:0]      prio_q [iodsq_pkg::NUM_CLASSES];

	logic [7:0]      mem_q  [MD];
	logic [7:0]      rdata_q;

	logic            strobe_q;
	logic [1:0]      kind_q;
	logic [1:0]      unit_q;
	logic [7:0]      pid_out_q;
	logic [1:0]      prio_out_q;
	logic            last_q;

	logic [QW-1:0]   cur_head;
	logic [FW-1:0]   cur_fill;
	logic [7:0]      cd_dec;
	logic            cur_full;
	logic [SW-1:0]   slot_sum;
	logic [QW-1:0]   slot;
	logic [QW-1:0]   head_next;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   rd_addr;
	logic            mem_we;
	logic            last_dev;
	logic [DW-1:0]   cur_inc;
	logic [1:0]      ridx_inc;
	logic            later_done;
	logic            req_bad;
	logic [1:0]      req_ridx;

	assign cur_head = head_q[cur_q];
	assign cur_fill = fill_q[cur_q];
	assign cd_dec   = cd_q[cur_q] - 8'd1;
	assign cur_full = (cur_fill == FW'(QUEUE_DEPTH));

	// tail slot, head + fill stays below twice the depth
	assign slot_sum = SW'(cur_head) + SW'(cur_fill);
	assign slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ?
		QW'(slot_sum - SW'(QUEUE_DEPTH)) : QW'(slot_sum);
	assign head_next = (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + QW'(1);

	assign wr_addr = AW'(int'(cur_q) * QUEUE_DEPTH + int'(slot));
	assign rd_addr = AW'(int'(cur_q) * QUEUE_DEPTH + int'(cur_head));
	assign mem_we  = (state_q == ST_REQ) && !bad_q && !cur_full;

	assign last_dev = (int'(cur_q) == DEVICES - 1);
	assign cur_inc  = cur_q + DW'(1);
	assign ridx_inc = (ridx_q == 2'd2) ? 2'd0 : ridx_q + 2'd1;

	assign req_bad  = (int'(device) >= DEVICES);
	assign req_ridx = (device == 2'd3) ? 2'd0 : device;

	// does any later device complete on this tick
	always_comb begin
		later_done = 1'b0;
		for (int j = 0; j < DEVICES; j++) begin
			if (j > int'(cur_q) && fill_q[j] != '0 && cd_q[j] == 8'd1) begin
				later_done = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= pid_q;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			ridx_q     <= '0;
			dev_q      <= '0;
			pid_q      <= '0;
			bad_q      <= 1'b0;
			strobe_q   <= 1'b0;
			kind_q     <= '0;
			unit_q     <= '0;
			pid_out_q  <= '0;
			prio_out_q <= '0;
			last_q     <= 1'b0;
			for (int i = 0; i < DEVICES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
				cd_q[i]   <= iodsq_pkg::DEV_DUR_RESET[i];
			end
			for (int i = 0; i < iodsq_pkg::NUM_CLASSES; i++) begin
				dur_q[i]  <= iodsq_pkg::DUR_RESET[i];
				prio_q[i] <= iodsq_pkg::PRIO_RESET[i];
			end
		end else begin
			strobe_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					iodsq_pkg::REG_DISK_DURATION:    dur_q[0]  <= cfg_data;
					iodsq_pkg::REG_TAPE_DURATION:    dur_q[1]  <= cfg_data;
					iodsq_pkg::REG_PRINTER_DURATION: dur_q[2]  <= cfg_data;
					iodsq_pkg::REG_DISK_PRIORITY:    prio_q[0] <= cfg_data[1:0];
					iodsq_pkg::REG_TAPE_PRIORITY:    prio_q[1] <= cfg_data[1:0];
					iodsq_pkg::REG_PRINTER_PRIORITY: prio_q[2] <= cfg_data[1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (func == iodsq_pkg::FUNC_REQUEST) begin
							dev_q   <= device;
							pid_q   <= pid;
							bad_q   <= req_bad;
							cur_q   <= req_bad ? '0 : DW'(device);
							ridx_q  <= req_ridx;
							state_q <= ST_REQ;
						end else begin
							cur_q   <= '0;
							ridx_q  <= '0;
							state_q <= ST_TCHK;
						end
					end
				end
				ST_REQ: begin
					strobe_q  <= 1'b1;
					unit_q    <= dev_q;
					pid_out_q <= pid_q;
					last_q    <= 1'b1;
					if (bad_q || cur_full) begin
						kind_q     <= iodsq_pkg::KIND_REJECT;
						prio_out_q <= '0;
					end else begin
						fill_q[cur_q] <= cur_fill + FW'(1);
						kind_q        <= iodsq_pkg::KIND_ACCEPT;
						prio_out_q    <= prio_q[ridx_q];
					end
					state_q <= ST_IDLE;
				end
				ST_TCHK: begin
					if (cur_fill != '0 && cd_dec == 8'd0) begin
						// completion: reload, pop, head pid comes from the memory
						cd_q[cur_q]   <= dur_q[ridx_q];
						head_q[cur_q] <= head_next;
						fill_q[cur_q] <= cur_fill - FW'(1);
						state_q       <= ST_TOUT;
					end else begin
						if (cur_fill != '0) begin
							cd_q[cur_q] <= cd_dec;
						end
						if (last_dev) begin
							state_q <= ST_IDLE;
						end else begin
							cur_q  <= cur_inc;
							ridx_q <= ridx_inc;
						end
					end
				end
				ST_TOUT: begin
					strobe_q   <= 1'b1;
					kind_q     <= iodsq_pkg::KIND_COMPLETE;
					unit_q     <= 2'(cur_q);
					pid_out_q  <= rdata_q;
					prio_out_q <= '0;
					last_q     <= !later_done;
					if (last_dev) begin
						state_q <= ST_IDLE;
					end else begin
						cur_q   <= cur_inc;
						ridx_q  <= ridx_inc;
						state_q <= ST_TCHK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign strobe          = strobe_q;
	assign kind            = kind_q;
	assign unit            = unit_q;
	assign process_id      = pid_out_q;
	assign return_priority = prio_out_q;
	assign last            = last_q;

endmodule

// ===== rtl/iodsq_chk.sv =====
// iodsq_chk: port checker for io_device_service_queues, bound to the top level.
// depends on iodsq_pkg.
module iodsq_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       func,
	input logic       strobe,
	input logic [1:0] kind,
	input logic [1:0] return_priority,
	input logic       last
);

	// a request answers with its single result, marked last
	a_req_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == iodsq_pkg::FUNC_REQUEST) |-> ##2 (strobe && last))
		else $error("request item without its result");

	// an accepted item keeps the block busy on the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted item");

	// more results pending means the tick walk is still running
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final result while idle");

	// request answers are always the only result of their item
	a_req_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind != iodsq_pkg::KIND_COMPLETE) |-> last)
		else $error("request result not marked last");

	a_prio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind != iodsq_pkg::KIND_ACCEPT) |-> (return_priority == 2'd0))
		else $error("priority on a result that is not an accept");

endmodule

bind io_device_service_queues iodsq_chk u_iodsq_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.func            (func),
	.strobe          (strobe),
	.kind            (kind),
	.return_priority (return_priority),
	.last            (last)
);

// ===== dv/tb_io_device_service_queues.sv =====
// tb_io_device_service_queues: self-checking bench for the i/o device service queues,
// a command driver fed from a queue, a result monitor and an in-bench queue predictor.
// depends on iodsq_pkg and io_device_service_queues.
`timescale 1ns / 1ps

module tb_io_device_service_queues;

	localparam int NUM_DEV = 3;
	localparam int QDEPTH  = 16;
	// indexes past the last register, writes there must be dropped
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {CMD_ITEM, CMD_CONFIG, CMD_DRAIN} cmd_kind_t;

	typedef struct {
		cmd_kind_t  what;
		logic       func;
		logic [1:0] device;
		logic [7:0] pid;
		logic [2:0] reg_index;
		logic [7:0] reg_value;
	} dev_cmd_t;

	typedef struct {
		logic [1:0] kind;
		logic [1:0] unit;
		logic [7:0] process_id;
		logic [1:0] return_priority;
		logic       last;
	} svc_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = 3'd0;
	logic [7:0] cfg_data = 8'd0;
	logic       start = 1'b0;
	logic       busy;
	logic       func = 1'b0;
	logic [1:0] device = 2'd0;
	logic [7:0] pid = 8'd0;
	logic       strobe;
	logic [1:0] kind;
	logic [1:0] unit;
	logic [7:0] process_id;
	logic [1:0] return_priority;
	logic       last;

	io_device_service_queues #(
		.DEVICES     (NUM_DEV),
		.QUEUE_DEPTH (QDEPTH)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.device          (device),
		.pid             (pid),
		.strobe          (strobe),
		.kind            (kind),
		.unit            (unit),
		.process_id      (process_id),
		.return_priority (return_priority),
		.last            (last)
	);

	always #2 clk = ~clk;

	dev_cmd_t    dev_cmds[$];
	svc_result_t due_results[$];

	// predicted device state
	logic [7:0] dur_set [3];
	logic [1:0] prio_set [3];
	logic [7:0] waiting [NUM_DEV][QDEPTH];
	int         head [NUM_DEV];
	int         fill [NUM_DEV];
	logic [7:0] count_left [NUM_DEV];

	int bad_results = 0;

	// advance the predicted queues by one accepted item and queue its results
	task automatic serve_item(input dev_cmd_t w);
		svc_result_t r;
		logic [1:0]  done_unit [NUM_DEV];
		logic [7:0]  done_pid [NUM_DEV];
		int          n;
		int          slot;
		n = 0;
		if (w.func == iodsq_pkg::FUNC_REQUEST) begin
			r.kind = iodsq_pkg::KIND_REJECT;
			r.unit = w.device;
			r.process_id = w.pid;
			r.return_priority = 2'd0;
			r.last = 1'b1;
			if (w.device < NUM_DEV) begin
				if (fill[w.device] < QDEPTH) begin
					slot = (head[w.device] + fill[w.device]) % QDEPTH;
					waiting[w.device][slot] = w.pid;
					fill[w.device]++;
					r.kind = iodsq_pkg::KIND_ACCEPT;
					r.return_priority = prio_set[w.device];
				end
			end
			due_results.push_back(r);
		end else begin
			for (int d = 0; d < NUM_DEV; d++) begin
				if (fill[d] != 0) begin
					count_left[d] = count_left[d] - 8'd1;
					if (count_left[d] == 8'd0) begin
						done_unit[n] = 2'(d);
						done_pid[n] = waiting[d][head[d]];
						count_left[d] = dur_set[d % 3];
						head[d] = (head[d] + 1) % QDEPTH;
						fill[d]--;
						n++;
					end
				end
			end
			for (int k = 0; k < n; k++) begin
				r.kind = iodsq_pkg::KIND_COMPLETE;
				r.unit = done_unit[k];
				r.process_id = done_pid[k];
				r.return_priority = 2'd0;
				r.last = (k == n - 1);
				due_results.push_back(r);
			end
		end
	endtask

	task automatic add_item(input logic f, input logic [1:0] dv, input logic [7:0] p);
		dev_cmd_t c;
		c.what = CMD_ITEM;
		c.func = f;
		c.device = dv;
		c.pid = p;
		c.reg_index = 3'd0;
		c.reg_value = 8'd0;
		dev_cmds.push_back(c);
	endtask

	task automatic add_cfg(input logic [2:0] idx, input logic [7:0] val);
		dev_cmd_t c;
		c.what = CMD_CONFIG;
		c.func = iodsq_pkg::FUNC_TICK;
		c.device = 2'd0;
		c.pid = 8'd0;
		c.reg_index = idx;
		c.reg_value = val;
		dev_cmds.push_back(c);
	endtask

	task automatic add_drain();
		dev_cmd_t c;
		c.what = CMD_DRAIN;
		c.func = iodsq_pkg::FUNC_TICK;
		c.device = 2'd0;
		c.pid = 8'd0;
		c.reg_index = 3'd0;
		c.reg_value = 8'd0;
		dev_cmds.push_back(c);
	endtask

	// settings are only changed once the block has gone quiet
	task automatic set_all(input logic [7:0] d0, input logic [7:0] d1, input logic [7:0] d2,
			input logic [1:0] p0, input logic [1:0] p1, input logic [1:0] p2);
		add_drain();
		add_cfg(iodsq_pkg::REG_DISK_DURATION, d0);
		add_cfg(iodsq_pkg::REG_TAPE_DURATION, d1);
		add_cfg(iodsq_pkg::REG_PRINTER_DURATION, d2);
		add_cfg(iodsq_pkg::REG_DISK_PRIORITY, {6'($urandom), p0});
		add_cfg(iodsq_pkg::REG_TAPE_PRIORITY, {6'($urandom), p1});
		add_cfg(iodsq_pkg::REG_PRINTER_PRIORITY, {6'($urandom), p2});
	endtask

	// favor < 0 spreads requests evenly over devices 0 to 2; 6 in 100 go to the bad device 3
	task automatic rand_phase(input int n, input int req_pct, input int favor);
		int         r;
		logic [1:0] dv;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				dv = 2'd3;
			else if (favor >= 0 && r < 60)
				dv = 2'(favor);
			else
				dv = 2'($urandom_range(0, 2));
			add_item(($urandom_range(0, 99) < req_pct) ?
				iodsq_pkg::FUNC_REQUEST : iodsq_pkg::FUNC_TICK, dv,
				8'($urandom_range(0, 255)));
		end
	endtask

	// driver
	dev_cmd_t cur;
	logic     took;
	logic     next_start;
	logic     next_we;
	int       gap_left = 0;
	int       burst_left = 0;
	int       quiet_cycles = 0;

	always @(posedge clk) begin
		took = start && !busy;
		next_start = 1'b0;
		next_we = 1'b0;
		if (took) begin
			serve_item(cur);
			if (burst_left > 0) begin
				burst_left--;
				gap_left = 0;
			end else if ($urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(4, 15);
				gap_left = 0;
			end else begin
				gap_left = $urandom_range(0, 18);
			end
		end
		if (arst_n) begin
			if (start && !took) begin
				next_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (dev_cmds.size() > 0) begin
				case (dev_cmds[0].what)
					CMD_ITEM: begin
						cur = dev_cmds[0];
						dev_cmds.delete(0);
						next_start = 1'b1;
						func <= cur.func;
						device <= cur.device;
						pid <= cur.pid;
					end
					CMD_CONFIG: begin
						if (dev_cmds[0].reg_index <= iodsq_pkg::REG_PRINTER_DURATION)
							dur_set[dev_cmds[0].reg_index] = dev_cmds[0].reg_value;
						else if (dev_cmds[0].reg_index <= iodsq_pkg::REG_PRINTER_PRIORITY)
							prio_set[dev_cmds[0].reg_index - iodsq_pkg::REG_DISK_PRIORITY] =
								dev_cmds[0].reg_value[1:0];
						cfg_index <= dev_cmds[0].reg_index;
						cfg_data <= dev_cmds[0].reg_value;
						next_we = 1'b1;
						dev_cmds.delete(0);
					end
					default: begin
						// a tick that completes nothing leaves no result to wait on
						if (due_results.size() == 0 && !busy)
							quiet_cycles++;
						else
							quiet_cycles = 0;
						if (quiet_cycles >= 4) begin
							quiet_cycles = 0;
							dev_cmds.delete(0);
						end
					end
				endcase
			end
		end
		start <= next_start;
		cfg_we <= next_we;
	end

	// monitor
	svc_result_t want;

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (due_results.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("unexpected result: kind %0d unit %0d pid %0d prio %0d last %0d",
						kind, unit, process_id, return_priority, last);
			end else begin
				want = due_results.pop_front();
				if (kind !== want.kind || unit !== want.unit ||
						process_id !== want.process_id ||
						return_priority !== want.return_priority || last !== want.last) begin
					bad_results++;
					if (bad_results <= 10) begin
						$display("%0t mismatch: expected kind %0d unit %0d pid %0d prio %0d last %0d",
							$realtime, want.kind, want.unit, want.process_id,
							want.return_priority, want.last);
						$display("  got kind %0d unit %0d pid %0d prio %0d last %0d",
							kind, unit, process_id, return_priority, last);
					end
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < 3; i++) begin
			dur_set[i] = iodsq_pkg::DUR_RESET[i];
			prio_set[i] = iodsq_pkg::PRIO_RESET[i];
		end
		for (int d = 0; d < NUM_DEV; d++) begin
			head[d] = 0;
			fill[d] = 0;
			count_left[d] = dur_set[d % 3];
		end

		// reset settings: one request per device, a bad device, then enough ticks
		// for every device to finish once
		add_item(iodsq_pkg::FUNC_REQUEST, 2'd0, 8'h00);
		add_item(iodsq_pkg::FUNC_REQUEST, 2'd1, 8'hFF);
		add_item(iodsq_pkg::FUNC_REQUEST, 2'd2, 8'hAA);
		add_item(iodsq_pkg::FUNC_REQUEST, 2'd3, 8'h55);
		for (int i = 0; i < 20; i++)
			add_item(iodsq_pkg::FUNC_TICK, (i % 2) ? 2'd3 : 2'd0, (i % 2) ? 8'hFF : 8'h00);

		set_all(8'd1, 8'd1, 8'd1, 2'd3, 2'd3, 2'd3);
		rand_phase(50, 50, -1);
		set_all(8'd2, 8'd3, 8'd1, 2'd2, 2'd3, 2'd1);
		add_cfg(REG_SPARE_LO, 8'($urandom));
		add_cfg(REG_SPARE_HI, 8'($urandom));
		rand_phase(50, 40, -1);
		set_all(8'd3, 8'd1, 8'd2, 2'd1, 2'd0, 2'd3);
		rand_phase(50, 45, 0);
		// zero duration wraps the printer countdown
		set_all(8'd1, 8'd5, 8'd0, 2'd3, 2'd0, 2'd2);
		rand_phase(40, 35, 2);
		// long durations so the tape queue fills and rejects
		set_all(8'd255, 8'd200, 8'd255, 2'd0, 2'd1, 2'd2);
		rand_phase(60, 90, 1);
		add_drain();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (dev_cmds.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (bad_results == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#1000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/iodsq_pkg.sv
rtl/io_device_service_queues.sv
rtl/iodsq_chk.sv
dv/tb_io_device_service_queues.sv
